>>> hdl/chtdp_pkg.sv
// ----------------------------------------------------------------------------
// chtdp_pkg
// Shared widths, codes and control structs for the convex hull trick DP core.
// ----------------------------------------------------------------------------
package chtdp_pkg;

    localparam int MAX_LEN = 1024;                      // items per sequence, line store depth
    localparam int IDX_W   = $clog2(MAX_LEN + 1);       // index / hull size counters
    localparam int ADDR_W  = $clog2(MAX_LEN);           // line store address

    localparam int VAL_W   = 16;                        // input value
    localparam int PS_W    = 32;                        // prefix sum
    localparam int DP_W    = 48;                        // dp value, line intercept
    localparam int SL_W    = PS_W + 1;                  // signed line slope
    localparam int LINE_W  = SL_W + DP_W;               // one store entry

    localparam int X_W     = DP_W + 1;                  // signed multiplier operand
    localparam int Y_W     = PS_W;                      // unsigned multiplier operand
    localparam int XL_W    = 24;                        // low slice of X
    localparam int XH_W    = X_W - XL_W;                // high (signed) slice of X
    localparam int ACC_W   = X_W + Y_W + 2;             // difference of two products

    localparam logic [DP_W-1:0] DP_MAX = '1;

    typedef enum logic [1:0] {
        PH_POP,
        PH_SRCH,
        PH_FIN
    } t_phase;

    typedef struct packed {
        logic              accept;
        logic              res_prev;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              ops_load;
        t_phase            ops_sel;
        logic              mul_en;
        logic [1:0]        mul_sel;    // [1] term, [0] high slice
        logic              acc_add;
        logic              res_load;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              out_load;
        logic              ovf;
    } t_cmd;

    typedef struct packed {
        logic seq_full;
        logic v_zero;
        logic last;
        logic acc_neg;
    } t_sts;

endpackage

>>> hdl/chtdp_dpath.sv
// ----------------------------------------------------------------------------
// chtdp_dpath
// Sequence state, line store, sliced multiply-accumulate and result registers.
// ----------------------------------------------------------------------------
module chtdp_dpath
    import chtdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_last,
    output t_sts             o_sts,
    output logic [DP_W-1:0]  o_dp_value,
    output logic             o_overflow
);

    logic [PS_W-1:0]          r_prefix;
    logic [DP_W-1:0]          r_prev;
    logic [IDX_W-1:0]         r_index;
    logic                     r_v_zero;
    logic                     r_last;
    logic [IDX_W-1:0]         r_i;
    logic [PS_W:0]            r_newp;
    logic signed [SL_W-1:0]   r_a;
    logic [DP_W-1:0]          r_b;

    logic [LINE_W-1:0]        r_mem [MAX_LEN];
    logic [LINE_W-1:0]        r_rd_a;
    logic [LINE_W-1:0]        r_rd_b;

    logic signed [X_W-1:0]    r_x0, r_x1;
    logic [Y_W-1:0]           r_y0, r_y1;
    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DP_W-1:0]          r_res;
    logic [DP_W-1:0]          r_dp_out;
    logic                     r_ovf_out;

    logic                     w_full;
    logic [PS_W-1:0]          w_pre;
    logic signed [X_W-1:0]    w_sl_a, w_sl_b, w_in_a, w_in_b, w_sn, w_sd_x;
    logic signed [X_W-1:0]    w_cn, w_cd_x, w_fin_x;
    logic signed [X_W-1:0]    w_mx;
    logic [Y_W-1:0]           w_my;
    logic [XL_W+Y_W-1:0]      w_p_lo;
    logic signed [XH_W+Y_W:0] w_p_hi;
    logic signed [ACC_W-1:0]  w_addend;

    assign w_full = (r_index >= IDX_W'(MAX_LEN));
    assign w_pre  = w_full ? '0 : r_prefix;

    // operands from the two read ports: A is line k, B is line k-1
    assign w_sl_a  = X_W'($signed(r_rd_a[LINE_W-1 -: SL_W]));
    assign w_sl_b  = X_W'($signed(r_rd_b[LINE_W-1 -: SL_W]));
    assign w_in_a  = X_W'(r_rd_a[DP_W-1:0]);
    assign w_in_b  = X_W'(r_rd_b[DP_W-1:0]);
    assign w_sn    = w_in_a - w_in_b;
    assign w_sd_x  = w_sl_b - w_sl_a;
    assign w_cn    = X_W'(r_b) - w_in_a;
    assign w_cd_x  = w_sl_a - X_W'(r_a);
    assign w_fin_x = w_sl_a + X_W'(r_newp);

    assign w_mx    = i_cmd.mul_sel[1] ? r_x1 : r_x0;
    assign w_my    = i_cmd.mul_sel[1] ? r_y1 : r_y0;
    assign w_p_lo  = w_mx[XL_W-1:0] * w_my;
    assign w_p_hi  = $signed(w_mx[X_W-1:XL_W]) * $signed({1'b0, w_my});

    assign w_addend = r_prod ^ {ACC_W{r_neg}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_prev   <= '0;
            r_index  <= '0;
        end else if (i_cmd.out_load) begin
            if (r_last) begin
                r_prefix <= '0;
                r_prev   <= '0;
                r_index  <= '0;
            end else begin
                r_prefix <= r_newp[PS_W-1:0];
                r_prev   <= r_res;
                r_index  <= r_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v_zero <= (i_value == '0);
            r_last   <= i_last;
            r_i      <= w_full ? IDX_W'(1) : r_index + IDX_W'(1);
            r_newp   <= {1'b0, w_pre} + (PS_W + 1)'(i_value);
            r_a      <= $signed(SL_W'(0) - {1'b0, w_pre});
            r_b      <= w_full ? '0 : r_prev;
        end
    end

    // line store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= {r_a, r_b};
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[i_cmd.rd_addr_a];
            r_rd_b <= r_mem[i_cmd.rd_addr_b];
        end
    end

    // acc = x0*y0 - x1*y1; final phase: acc = intercept + i + x0*y0
    always_ff @(posedge i_clk) begin
        if (i_cmd.ops_load) begin
            case (i_cmd.ops_sel)
                PH_POP: begin
                    r_x0  <= w_sn;
                    r_y0  <= w_cd_x[Y_W-1:0];
                    r_x1  <= w_cn;
                    r_y1  <= w_sd_x[Y_W-1:0];
                    r_acc <= '0;
                end
                PH_SRCH: begin
                    r_x0  <= w_sn;
                    r_y0  <= Y_W'(1);
                    r_x1  <= X_W'(r_i);
                    r_y1  <= w_sd_x[Y_W-1:0];
                    r_acc <= '0;
                end
                default: begin
                    r_x0  <= w_fin_x;
                    r_y0  <= Y_W'(r_i);
                    r_acc <= ACC_W'(r_rd_a[DP_W-1:0]) + ACC_W'(r_i);
                end
            endcase
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_addend + ACC_W'(r_neg);
        end
        if (i_cmd.mul_en) begin
            r_prod <= i_cmd.mul_sel[0] ? (ACC_W'(w_p_hi) <<< XL_W) : ACC_W'(w_p_lo);
            r_neg  <= i_cmd.mul_sel[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_prev) begin
            r_res <= r_b;
        end else if (i_cmd.res_load) begin
            if (r_acc[ACC_W-1]) begin
                r_res <= '0;
            end else if (|r_acc[ACC_W-2:DP_W]) begin
                r_res <= DP_MAX;
            end else begin
                r_res <= r_acc[DP_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_dp_out  <= r_res;
            r_ovf_out <= i_cmd.ovf;
        end
    end

    assign o_sts.seq_full = w_full;
    assign o_sts.v_zero   = r_v_zero;
    assign o_sts.last     = r_last;
    assign o_sts.acc_neg  = r_acc[ACC_W-1];
    assign o_dp_value     = r_dp_out;
    assign o_overflow     = r_ovf_out;

endmodule

>>> hdl/chtdp_ctrl.sv
// ----------------------------------------------------------------------------
// chtdp_ctrl
// Sequencer: hull pops, line push, binary search, final evaluation, handshakes.
// ----------------------------------------------------------------------------
module chtdp_ctrl
    import chtdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_RD,
        S_OPS,
        S_MAC,
        S_EVAL,
        S_PUSH,
        S_OUT
    } t_state;

    t_state           r_state;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_hull;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic [2:0]       r_cnt;
    logic             r_ovf;
    logic             r_out_valid;

    logic [IDX_W:0]   w_sum;
    logic [IDX_W-1:0] w_mid;
    logic [2:0]       w_nsteps;
    logic [IDX_W-1:0] n_lo;
    logic [IDX_W-1:0] n_hi;
    logic [IDX_W-1:0] n_push_hi;
    logic [IDX_W-1:0] n_pop_hull;
    logic             w_room;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[IDX_W:1];
    assign w_nsteps   = (r_phase == PH_FIN) ? 3'd2 : 3'd4;
    assign w_room     = (r_hull < IDX_W'(MAX_LEN));
    assign n_push_hi  = w_room ? r_hull + IDX_W'(1) : r_hull;
    assign n_pop_hull = r_hull - IDX_W'(1);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_sts.acc_neg) begin
            n_lo = r_mid;
        end else begin
            n_hi = r_mid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.ops_sel  = r_phase;
        o_cmd.mul_sel  = r_cnt[1:0];
        o_cmd.wr_addr  = r_hull[ADDR_W-1:0];
        o_cmd.ovf      = r_ovf;
        unique case (r_state)
            S_IDLE: o_cmd.accept = i_in_valid;
            S_CHK:  o_cmd.res_prev = i_sts.v_zero;
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                unique case (r_phase)
                    PH_POP: begin
                        o_cmd.rd_addr_a = n_pop_hull[ADDR_W-1:0];
                        o_cmd.rd_addr_b = ADDR_W'(r_hull - IDX_W'(2));
                    end
                    PH_SRCH: begin
                        o_cmd.rd_addr_a = w_mid[ADDR_W-1:0];
                        o_cmd.rd_addr_b = ADDR_W'(w_mid - IDX_W'(1));
                    end
                    default: begin
                        o_cmd.rd_addr_a = r_lo[ADDR_W-1:0];
                        o_cmd.rd_addr_b = r_lo[ADDR_W-1:0];
                    end
                endcase
            end
            S_OPS:  o_cmd.ops_load = 1'b1;
            S_MAC: begin
                o_cmd.mul_en  = (r_cnt < w_nsteps);
                o_cmd.acc_add = (r_cnt != 3'd0);
            end
            S_EVAL: o_cmd.res_load = (r_phase == PH_FIN);
            S_PUSH: o_cmd.wr_en = w_room;
            S_OUT:  o_cmd.out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_POP;
            r_hull      <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_mid       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_sts.seq_full) begin
                            r_hull <= '0;
                        end
                        r_ovf   <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (i_sts.v_zero) begin
                        r_state <= S_OUT;
                    end else if (r_hull >= IDX_W'(2)) begin
                        r_phase <= PH_POP;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_RD: begin
                    r_mid   <= w_mid;
                    r_state <= S_OPS;
                end
                S_OPS: begin
                    r_cnt   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == w_nsteps) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    unique case (r_phase)
                        PH_POP: begin
                            if (!i_sts.acc_neg) begin
                                r_hull  <= n_pop_hull;
                                r_state <= (n_pop_hull >= IDX_W'(2)) ? S_RD : S_PUSH;
                            end else begin
                                r_state <= S_PUSH;
                            end
                        end
                        PH_SRCH: begin
                            r_lo    <= n_lo;
                            r_hi    <= n_hi;
                            r_state <= S_RD;
                            if (!((n_lo + IDX_W'(1)) < n_hi)) begin
                                r_phase <= PH_FIN;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_PUSH: begin
                    r_hull  <= n_push_hi;
                    r_lo    <= '0;
                    r_hi    <= n_push_hi;
                    r_ovf   <= !w_room;
                    r_phase <= (n_push_hi > IDX_W'(1)) ? PH_SRCH : PH_FIN;
                    r_state <= S_RD;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        if (i_sts.last) begin
                            r_hull <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_hull_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hull <= IDX_W'(MAX_LEN))
        else $error("hull size beyond store depth");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_phase == PH_SRCH) |-> (r_lo + IDX_W'(1) < r_hi))
        else $error("binary search window empty");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (r_hull < IDX_W'(MAX_LEN)))
        else $error("line written past store end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> r_state == S_OUT)
        else $error("result left while output slot busy");
`endif

endmodule

>>> hdl/convex_hull_trick_dp_core.sv
// ----------------------------------------------------------------------------
// convex_hull_trick_dp_core
// DP over a stream of values using a monotone-slope lower envelope of lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata[15:0] = value, tlast = last item of a sequence.
//   Output stream m_axis: tdata[47:0] = dp_value, tuser[0] = overflow.
//   One result item per input item, in order.
// Work per item (accept to next possible accept):
//   zero value: the previous dp value is passed to the output register.
//   nonzero: T pop tests, a push, S search steps and a final evaluation.
//   T = pop tests: lines popped, plus one when the scan stops at a line
//   that stays (none while the hull holds fewer than two lines).
//   S = search steps, floor or ceil of log2(H), H = hull size after the
//   push. Each pop test and search step is one store read, operand setup
//   and four sliced 24/25x32 multiplies through a single multiplier and
//   accumulator, which sets the per-step cost.
// Throughput: one item in flight; s_axis_tready is high only while idle,
//   and the next item is taken as soon as the prior result sits in the
//   output register, even if the receiver has not taken it yet.
// Stall: a result waits in the output register while m_axis_tready is low;
//   a further finished result holds the sequencer until the slot frees.
// Reset (i_rst_n low, synchronous): sequence state and hull size clear,
//   the line store is not cleared (only entries below hull size are read).
// ----------------------------------------------------------------------------
module convex_hull_trick_dp_core
    import chtdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] value
    input  logic        s_axis_tlast,    // last item of the sequence

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // [47:0] dp_value
    output logic [0:0]  m_axis_tuser     // [0] overflow
);

    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [DP_W-1:0] w_dp_value;
    logic            w_overflow;

    // sequencer: pops, push, search, final evaluation and both handshakes
    chtdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // state registers, line store, multiply-accumulate, output register
    chtdp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_value    (s_axis_tdata[VAL_W-1:0]),
        .i_last     (s_axis_tlast),
        .o_sts      (w_sts),
        .o_dp_value (w_dp_value),
        .o_overflow (w_overflow)
    );

    assign m_axis_tdata    = w_dp_value;
    assign m_axis_tuser[0] = w_overflow;

endmodule

>>> dv/convex_hull_trick_dp_checker.sv
// ----------------------------------------------------------------------------
// convex_hull_trick_dp_checker
// Watches both streams of the DP core, predicts each result item from the
// accepted input items and compares field by field in order.
// ----------------------------------------------------------------------------
module convex_hull_trick_dp_checker
    import chtdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [DP_W-1:0] dp;
        logic            ovf;
    } t_dp_res;

    t_dp_res         dp_queue[$];
    longint unsigned run_sum;
    longint unsigned last_dp;
    int unsigned     item_idx;
    int unsigned     env_size;
    longint          env_slope[MAX_LEN];
    longint          env_icpt[MAX_LEN];

    assign o_pending = dp_queue.size();

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic void clear_seq();
        run_sum  = 0;
        last_dp  = 0;
        item_idx = 0;
        env_size = 0;
    endfunction

    // sign of n1*d2 - n2*d1, exact at 128 bits
    function automatic int frac_cmp(longint n1, longint unsigned d1,
                                    longint n2, longint unsigned d2);
        logic signed [127:0] a, b, c, d;
        a = 128'(n1);
        c = 128'(n2);
        b = $signed({64'd0, d2});
        d = $signed({64'd0, d1});
        a = a * b;
        c = c * d;
        if (a < c) return -1;
        if (a > c) return 1;
        return 0;
    endfunction

    function automatic void start_pt(int unsigned k, output longint num,
                                     output longint unsigned den);
        num = env_icpt[k] - env_icpt[k-1];
        den = longint'(env_slope[k-1] - env_slope[k]);
    endfunction

    function automatic t_dp_res predict_dp(logic [15:0] v, logic last);
        t_dp_res         r;
        longint unsigned i, newp, res;
        longint          a, b, sn, cn, val;
        longint unsigned sd, cd;
        int unsigned     lo, hi, mid;
        r.ovf = 1'b0;
        if (item_idx >= MAX_LEN) clear_seq();
        i    = item_idx + 1;
        newp = run_sum + v;
        if (v != 0) begin
            a = -longint'(run_sum);
            b = longint'(last_dp);
            // drop tail lines that the new line hides
            while (env_size >= 2) begin
                start_pt(env_size - 1, sn, sd);
                cn = b - env_icpt[env_size-1];
                cd = longint'(env_slope[env_size-1] - a);
                if (frac_cmp(sn, sd, cn, cd) >= 0) env_size--;
                else break;
            end
            if (env_size < MAX_LEN) begin
                env_slope[env_size] = a;
                env_icpt[env_size]  = b;
                env_size++;
            end else begin
                r.ovf = 1'b1;
            end
            lo = 0;
            hi = env_size;
            while (lo + 1 < hi) begin
                mid = (lo + hi) / 2;
                start_pt(mid, sn, sd);
                if (frac_cmp(sn, sd, longint'(i), 1) < 0) lo = mid;
                else hi = mid;
            end
            val = env_slope[lo] * longint'(i) + env_icpt[lo]
                + longint'(newp * i) + longint'(i);
            if (val < 0) res = 0;
            else if (longint'(val) > longint'({16'd0, DP_MAX})) res = {16'd0, DP_MAX};
            else res = val;
        end else begin
            res = last_dp;
        end
        run_sum  = newp & 64'hFFFF_FFFF;
        last_dp  = res;
        item_idx = i;
        r.dp     = res[DP_W-1:0];
        if (last) clear_seq();
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        clear_seq();
    end

    always @(posedge i_clk) begin
        t_dp_res got, want, pred;
        if (!i_rst_n) begin
            clear_seq();
            dp_queue.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                pred = predict_dp(i_s_tdata, i_s_tlast);
                dp_queue.insert(dp_queue.size(), pred);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.dp  = i_m_tdata;
                got.ovf = i_m_tuser[0];
                if (dp_queue.size() == 0) begin
                    report($sformatf("unexpected result dp=%0d", got.dp));
                end else begin
                    want = dp_queue.pop_front();
                    if (got.dp !== want.dp)
                        report($sformatf("dp_value %0d, want %0d", got.dp, want.dp));
                    if (got.ovf !== want.ovf)
                        report($sformatf("overflow %0b, want %0b", got.ovf, want.ovf));
                end
            end
        end
    end

endmodule

>>> dv/convex_hull_trick_dp_core_tb.sv
// ----------------------------------------------------------------------------
// convex_hull_trick_dp_core_tb
// Drives value sequences into the DP core with random gaps and back-pressure;
// the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module convex_hull_trick_dp_core_tb;
    import chtdp_pkg::*;

    localparam int WD_LIMIT = 40000;    // idle cycles before giving up

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;          // [15:0] value
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;          // [47:0] dp_value
    logic [0:0]  m_axis_tuser;          // [0] overflow

    int fail_count;
    int pending;
    int idle_cycles;
    bit quiet_mode;                     // no source gaps / sink stalls
    int stall_left;

    convex_hull_trick_dp_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    convex_hull_trick_dp_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (quiet_mode || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= gap_len();
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("timeout waiting for a handshake");
            $display("convex_hull_trick_dp_core_tb NOT OK");
            $finish;
        end
    end

    // one item: optional gap, then hold tvalid until accepted
    task automatic send_item(input logic [15:0] v, input logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // value mix: zeros, extremes, small, full range
    function automatic logic [15:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 16'd0;
        if (r < 25) return 16'hFFFF;
        if (r < 55) return 16'($urandom_range(1, 20));
        return 16'($urandom);
    endfunction

    initial begin
        int len;
        idle_cycles   = 0;
        quiet_mode    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero first, field extremes, bit patterns, single-item runs
        send_item(16'd0,     1'b0);
        send_item(16'hFFFF,  1'b0);
        send_item(16'd1,     1'b0);
        send_item(16'd0,     1'b0);
        send_item(16'hAAAA,  1'b0);
        send_item(16'h5555,  1'b1);
        send_item(16'd7,     1'b1);     // one-item sequence
        send_item(16'd0,     1'b1);     // zero-only sequence
        send_item(16'd0,     1'b0);
        send_item(16'd0,     1'b1);
        for (int k = 0; k < 10; k++)    // dense pops: ramp down then spike
            send_item(k == 9 ? 16'hFFFF : 16'(10 - k), k == 9);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h8000, 1'b1);

        // random sequences, a burst-free stretch now and then
        for (int s = 0; s < 38; s++) begin
            quiet_mode = ($urandom_range(4) == 0);
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 14);
            for (int k = 0; k < len; k++)
                send_item(rand_value(), k == len - 1);
        end
        quiet_mode = 1'b0;

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("convex_hull_trick_dp_core_tb OK");
        else
            $display("convex_hull_trick_dp_core_tb NOT OK");
        $finish;
    end

endmodule
